// ----- design/sha512_pkg.sv -----
`timescale 1ns / 1ps
package sha512_pkg;

    localparam int unsigned ROUNDS = 80;

    typedef enum logic [2:0] {
        SEL_WORD  = 3'd0,
        SEL_LAST  = 3'd1,
        SEL_MARK  = 3'd2,
        SEL_ZERO  = 3'd3,
        SEL_LENHI = 3'd4,
        SEL_LENLO = 3'd5
    } push_sel_t;

    typedef struct packed {
        logic      push;
        push_sel_t sel;
        logic      count;
        logic      load;
        logic      round;
        logic [6:0] rnd;
        logic      finalize;
        logic      restart;
        logic [2:0] idx;
    } sha_cmd_t;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] big_sigma0(input logic [63:0] x);
        big_sigma0 = {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
    endfunction

    function automatic logic [63:0] big_sigma1(input logic [63:0] x);
        big_sigma1 = {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
    endfunction

    function automatic logic [63:0] small_sigma0(input logic [63:0] x);
        small_sigma0 = {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ {7'd0, x[63:7]};
    endfunction

    function automatic logic [63:0] small_sigma1(input logic [63:0] x);
        small_sigma1 = {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ {6'd0, x[63:6]};
    endfunction

endpackage

// ----- design/sha512_ctrl.sv -----
`timescale 1ns / 1ps
module sha512_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                message_valid,
    output logic                message_ready,
    input  logic [3:0]          byte_count,
    input  logic                end_of_message,
    output logic                digest_valid,
    input  logic                digest_ready,
    output logic [2:0]          word_index,
    output logic                last_word,
    output sha512_pkg::sha_cmd_t cmd
);
    import sha512_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FINAL = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] fill_reg, fill_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       mark_reg, mark_next;      // 0x80 marker still owed
    logic       lenok_reg, lenok_next;    // length may go in slots 14/15 of this block
    logic       lendone_reg, lendone_next;
    logic       pad_reg, pad_next;        // padding in progress

    assign message_ready = (state_reg == ST_IDLE);
    assign digest_valid  = (state_reg == ST_OUT);
    assign word_index    = idx_reg;
    assign last_word     = (idx_reg == 3'd7);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        mark_next    = mark_reg;
        lenok_next   = lenok_reg;
        lendone_next = lendone_reg;
        pad_next     = pad_reg;
        cmd          = '0;
        cmd.sel      = SEL_ZERO;
        cmd.rnd      = rnd_reg;
        cmd.idx      = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (message_valid)
                begin
                    cmd.push  = 1'b1;
                    cmd.count = 1'b1;
                    fill_next = fill_reg + 4'd1;
                    if (!end_of_message || byte_count >= 4'd8)
                    begin
                        cmd.sel = SEL_WORD;
                    end
                    else
                    begin
                        cmd.sel = SEL_LAST;
                    end
                    if (end_of_message)
                    begin
                        pad_next   = 1'b1;
                        mark_next  = (byte_count >= 4'd8);
                        lenok_next = (fill_reg <= 4'd13);
                    end
                    if (fill_reg == 4'd15)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.push  = 1'b1;
                fill_next = fill_reg + 4'd1;
                priority if (mark_reg)
                begin
                    cmd.sel    = SEL_MARK;
                    mark_next  = 1'b0;
                    lenok_next = (fill_reg <= 4'd13);
                end
                else if (lenok_reg && fill_reg == 4'd14)
                begin
                    cmd.sel = SEL_LENHI;
                end
                else if (lenok_reg && fill_reg == 4'd15)
                begin
                    cmd.sel      = SEL_LENLO;
                    lendone_next = 1'b1;
                end
                else
                begin
                    cmd.sel = SEL_ZERO;
                end
                if (fill_reg == 4'd15)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (rnd_reg == 7'(ROUNDS - 1))
                begin
                    rnd_next   = '0;
                    state_next = ST_FINAL;
                end
                else
                begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            ST_FINAL:
            begin
                cmd.finalize = 1'b1;
                priority if (!pad_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (lendone_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    lenok_next = 1'b1;
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (digest_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.restart  = 1'b1;
                        pad_next     = 1'b0;
                        lendone_next = 1'b0;
                        lenok_next   = 1'b0;
                        mark_next    = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            rnd_reg     <= '0;
            idx_reg     <= '0;
            mark_reg    <= 1'b0;
            lenok_reg   <= 1'b0;
            lendone_reg <= 1'b0;
            pad_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rnd_reg     <= rnd_next;
            idx_reg     <= idx_next;
            mark_reg    <= mark_next;
            lenok_reg   <= lenok_next;
            lendone_reg <= lendone_next;
            pad_reg     <= pad_next;
        end
    end

endmodule

// ----- design/sha512_datapath.sv -----
`timescale 1ns / 1ps
module sha512_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha512_pkg::sha_cmd_t cmd,
    input  logic [63:0]          message_word,
    input  logic [3:0]           byte_count,
    input  logic                 end_of_message,
    output logic [63:0]          digest_word
);
    import sha512_pkg::*;

    logic [63:0]  chain_reg [8];
    logic [63:0]  chain_next [8];
    logic [63:0]  sched_reg [16];   // block buffer and rolling schedule in one shift line
    logic [63:0]  var_reg [8];
    logic [127:0] len_reg, len_next;
    logic [127:0] bit_len;
    logic [63:0]  push_word, last_word_val, wt, t1, t2;
    logic [3:0]   n_eff;

    assign n_eff   = (!end_of_message || byte_count >= 4'd8) ? 4'd8 : byte_count;
    assign bit_len = {len_reg[124:0], 3'b000};

    // short last word: keep n bytes, 0x80 in the next lane, zeros after
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < byte_count)
            begin
                last_word_val[63-8*i -: 8] = message_word[63-8*i -: 8];
            end
            else if (4'(i) == byte_count)
            begin
                last_word_val[63-8*i -: 8] = 8'h80;
            end
            else
            begin
                last_word_val[63-8*i -: 8] = 8'h00;
            end
        end
    end

    always_comb
    begin
        unique case (cmd.sel)
            SEL_WORD:  push_word = message_word;
            SEL_LAST:  push_word = last_word_val;
            SEL_MARK:  push_word = 64'h8000_0000_0000_0000;
            SEL_LENHI: push_word = bit_len[127:64];
            SEL_LENLO: push_word = bit_len[63:0];
            default:   push_word = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.rnd < 7'd16)
        begin
            wt = sched_reg[0];
        end
        else
        begin
            wt = sched_reg[0] + small_sigma0(sched_reg[1]) + sched_reg[9]
                 + small_sigma1(sched_reg[14]);
        end
        t1 = var_reg[7] + big_sigma1(var_reg[4])
             + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
             + K[cmd.rnd] + wt;
        t2 = big_sigma0(var_reg[0])
             + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                ^ (var_reg[1] & var_reg[2]));
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.restart)
        begin
            len_next = '0;
        end
        else if (cmd.count)
        begin
            len_next = len_reg + {124'd0, n_eff};
        end
        for (int i = 0; i < 8; i++)
        begin
            if (cmd.restart)
            begin
                chain_next[i] = IV[i];
            end
            else if (cmd.finalize)
            begin
                chain_next[i] = chain_reg[i] + var_reg[i];
            end
            else
            begin
                chain_next[i] = chain_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= IV[i];
            end
        end
        else
        begin
            len_reg <= len_next;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[15] <= cmd.push ? push_word : wt;
        end
        if (cmd.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                var_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round)
        begin
            for (int i = 1; i < 8; i++)
            begin
                var_reg[i] <= var_reg[i-1];
            end
            var_reg[4] <= var_reg[3] + t1;
            var_reg[0] <= t1 + t2;
        end
    end

    assign digest_word = chain_reg[cmd.idx];

endmodule

// ----- design/sha512_hash_engine.sv -----
`timescale 1ns / 1ps
// Channel   Valid/Ready                     Payload
// message   message_valid/message_ready     message_word, byte_count, end_of_message
// digest    digest_valid/digest_ready       digest_word, word_index, last_word
//
// One word is taken per cycle while a block fills; the 16th word of a block starts
// 80 rounds at one round per cycle, followed by the chain update.
// A final word adds padding pushes (one per cycle), one or two compressions, then
// eight digest transfers. Reset loads the initial hash and clears length and fill.
// A stalled digest holds the engine; no message word is taken until all eight leave.
module sha512_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        message_valid,
    output logic        message_ready,
    input  logic [63:0] message_word,
    input  logic [3:0]  byte_count,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [63:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha512_pkg::*;

    sha_cmd_t cmd;

    // controller: fill count, padding sequence, round counter, digest sequencing
    sha512_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .message_valid  (message_valid),
        .message_ready  (message_ready),
        .byte_count     (byte_count),
        .end_of_message (end_of_message),
        .digest_valid   (digest_valid),
        .digest_ready   (digest_ready),
        .word_index     (word_index),
        .last_word      (last_word),
        .cmd            (cmd)
    );

    // datapath: schedule shift line, round variables, chain value, length counter
    sha512_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .message_word   (message_word),
        .byte_count     (byte_count),
        .end_of_message (end_of_message),
        .digest_word    (digest_word)
    );

endmodule

// ----- verif/sha512_digest_checker.sv -----
`timescale 1ns / 1ps
module sha512_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        message_valid,
    input  logic        message_ready,
    input  logic [63:0] message_word,
    input  logic [3:0]  byte_count,
    input  logic        end_of_message,
    input  logic        digest_valid,
    input  logic        digest_ready,
    input  logic [63:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          fail_count,
    output int          pending_words,
    output int          digests_seen
);
    import sha512_pkg::*;

    typedef struct packed {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    // model state
    logic [63:0]  hash_state [8];
    logic [63:0]  block_words [16];
    int unsigned  fill_words;
    logic [127:0] byte_total;
    digest_item_t expected_digests [$];

    function automatic logic [63:0] ror(input logic [63:0] x, input int r);
        ror = (x >> r) | (x << (64 - r));
    endfunction

    task automatic compress_block();
        logic [63:0] w [16];
        logic [63:0] v [8];
        logic [63:0] wt, s0, s1, t1, t2, e, a;
        begin
            for (int i = 0; i < 8; i++) v[i] = hash_state[i];
            for (int t = 0; t < 80; t++) begin
                if (t < 16) begin
                    wt = block_words[t];
                end else begin
                    s0 = ror(w[(t + 1) & 15], 1) ^ ror(w[(t + 1) & 15], 8)
                         ^ (w[(t + 1) & 15] >> 7);
                    s1 = ror(w[(t + 14) & 15], 19) ^ ror(w[(t + 14) & 15], 61)
                         ^ (w[(t + 14) & 15] >> 6);
                    wt = w[t & 15] + s0 + w[(t + 9) & 15] + s1;
                end
                w[t & 15] = wt;
                e = v[4];
                a = v[0];
                t1 = v[7] + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41))
                     + ((e & v[5]) ^ (~e & v[6])) + K[t] + wt;
                t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39))
                     + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
                for (int i = 7; i > 0; i--) v[i] = v[i - 1];
                v[4] = v[4] + t1;
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
        end
    endtask

    task automatic append_word(input logic [63:0] x);
        begin
            block_words[fill_words] = x;
            fill_words++;
            if (fill_words == 16) begin
                compress_block();
                fill_words = 0;
            end
        end
    endtask

    task automatic restart_hash();
        begin
            for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
            fill_words = 0;
            byte_total = '0;
        end
    endtask

    task automatic absorb_transfer(input logic [63:0] x, input logic [3:0] n_in,
                                   input logic eom);
        int unsigned n;
        logic [63:0] keep;
        logic [127:0] bits;
        digest_item_t d;
        begin
            n = (n_in > 8) ? 8 : n_in;
            if (!eom) begin
                byte_total += 8;
                append_word(x);
            end else begin
                byte_total += n;
                if (n == 8) begin
                    append_word(x);
                    append_word(64'h80 << 56);
                end else begin
                    keep = (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
                    append_word((x & keep) | (64'h80 << (56 - 8 * n)));
                end
                if (fill_words > 14)
                    while (fill_words != 0) append_word('0);
                while (fill_words < 14) append_word('0);
                bits = byte_total << 3;
                append_word(bits[127:64]);
                append_word(bits[63:0]);
                for (int k = 0; k < 8; k++) begin
                    d.word = hash_state[k];
                    d.index = 3'(k);
                    d.last = (k == 7);
                    expected_digests.push_back(d);
                end
                restart_hash();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        digest_item_t d;
        if (!rst_n) begin
            restart_hash();
            expected_digests.delete();
            fail_count <= 0;
            digests_seen <= 0;
        end else begin
            if (message_valid && message_ready)
                absorb_transfer(message_word, byte_count, end_of_message);
            if (digest_valid && digest_ready) begin
                if (expected_digests.size() == 0) begin
                    $display("%0t: unexpected digest transfer word=%h idx=%0d", $time,
                             digest_word, word_index);
                    fail_count <= fail_count + 1;
                end else begin
                    d = expected_digests.pop_front();
                    if (d.word !== digest_word || d.index !== word_index
                        || d.last !== last_word) begin
                        $display("%0t: digest mismatch exp %h/%0d/%0b got %h/%0d/%0b",
                                 $time, d.word, d.index, d.last,
                                 digest_word, word_index, last_word);
                        fail_count <= fail_count + 1;
                    end
                    if (last_word) digests_seen <= digests_seen + 1;
                end
            end
        end
        pending_words = expected_digests.size();
    end
endmodule

// ----- verif/sha512_hash_engine_tb.sv -----
`timescale 1ns / 1ps
module sha512_hash_engine_tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        message_valid = 1'b0;
    logic        message_ready;
    logic [63:0] message_word = '0;
    logic [3:0]  byte_count = '0;
    logic        end_of_message = 1'b0;
    logic        digest_valid;
    logic        digest_ready = 1'b0;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int fail_count, pending_words, digests_seen;
    int send_idle_pct, recv_stall_pct;   // idling percentages of the current phase
    bit hold_receiver;                   // long receiver hold-off in progress
    int words_sent;
    int quiet_cycles;

    localparam int QUIET_LIMIT = 20000;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sha512_hash_engine i_dut (.*);

    sha512_digest_checker i_checker (.*);

    // receiver: random stalls, or a solid hold-off while hold_receiver is set
    always @(posedge clk)
    begin
        if (!rst_n)
            digest_ready <= 1'b0;
        else
            digest_ready <= !hold_receiver && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles in which neither channel makes a transfer
    always @(posedge clk)
    begin
        if ((message_valid && message_ready) || (digest_valid && digest_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT)
        begin
            $display("timeout: no transfer in %0d cycles", QUIET_LIMIT);
            $display("sha512_hash_engine_tb: FAIL");
            $finish;
        end
    end

    // one transfer on the message channel; valid stays up across back-to-back words
    task automatic send_word(input logic [63:0] w, input logic [3:0] n, input logic eom);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                message_valid <= 1'b0;
                @(posedge clk);
            end
            message_valid <= 1'b1;
            message_word <= w;
            byte_count <= n;
            end_of_message <= eom;
            @(posedge clk);
            while (!message_ready) @(posedge clk);
            words_sent++;
        end
    endtask

    function automatic logic [63:0] rand_word();
        rand_word = {$urandom(), $urandom()};
    endfunction

    // body words then a final word with the given tail byte count
    task automatic send_message(input int body_words, input logic [3:0] tail);
        begin
            for (int i = 0; i < body_words; i++)
                send_word(rand_word(), 4'($urandom_range(15)), 1'b0);
            send_word(rand_word(), tail, 1'b1);
        end
    endtask

    task automatic random_messages(input int n_words);
        int start;
        int len;
        begin
            start = words_sent;
            while (words_sent - start < n_words)
            begin
                // mostly short messages, some spanning several blocks
                len = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(18);
                send_message(len, 4'($urandom_range(15)));
            end
        end
    endtask

    initial
    begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_receiver = 1'b0;
        words_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, tail lengths 0..8, all-ones/zeros words,
        // full tail pushing the marker into the next word and block,
        // tail lengths 9 and 15, ignored counts on body words
        send_word(64'd0, 4'd0, 1'b1);
        send_word(~64'd0, 4'd8, 1'b1);
        send_word(~64'd0, 4'd15, 1'b1);
        send_word(64'd0, 4'd8, 1'b1);
        send_word(~64'd0, 4'd1, 1'b1);
        send_word(~64'd0, 4'd0, 1'b0);
        send_word(64'd0, 4'd3, 1'b1);
        send_message(13, 4'd8);   // final word fills word 14: two-block padding
        send_message(15, 4'd8);   // marker opens a new block
        for (int n = 2; n <= 7; n++)
            send_word(64'h0123456789abcdef, 4'(n), 1'b1);
        send_word(~64'd0, 4'd9, 1'b1);

        random_messages(70);
        send_idle_pct = 73;
        random_messages(60);
        send_idle_pct = 0;
        recv_stall_pct = 73;
        random_messages(60);
        send_idle_pct = 29;
        recv_stall_pct = 29;
        random_messages(60);

        // back-pressure: receiver holds off while messages keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_receiver = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_receiver = 1'b0;
            end
            random_messages(40);
        join
        random_messages(40);
        message_valid <= 1'b0;
        @(posedge clk);

        while (pending_words != 0) @(posedge clk);
        repeat (300) @(posedge clk);

        $display("covered %0d message words and %0d digests across idle/stall phases",
                 words_sent, digests_seen);
        if (fail_count == 0)
            $display("sha512_hash_engine_tb: PASS");
        else
            $display("sha512_hash_engine_tb: FAIL");
        $finish;
    end
endmodule
